@@ hdl/pdd_pkg.sv @@
package pdd_pkg;

    // Field widths
    localparam int LFSR_W   = 11;
    localparam int ADDR_F_W = 11;
    localparam int VALUE_W  = 15;
    localparam int DIFF_W   = 16;
    localparam int CAL_W    = 20;
    localparam int MEAN_W   = 16;
    localparam int RANGE_W  = 16;

    // Input tdata layout, lowest bit first: address, value
    localparam int ADDR_LSB  = 0;
    localparam int VALUE_LSB = ADDR_LSB + ADDR_F_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Calibration constants: offset 32.88327 in Q8, 1/55.9737 in Q24
    localparam logic signed [20:0] CAL_OFFSET_Q8 = 21'sd8418;
    localparam logic [18:0]        CAL_RECIP_Q24 = 19'd299734;
    localparam logic [54:0]        CAL_ROUND     = 55'h0_0000_8000_0000;
    localparam logic signed [24:0] CAL_MAX       = 25'sd524287;
    localparam logic signed [24:0] CAL_MIN       = -25'sd524288;

    typedef enum logic [1:0] {
        OP_WR_RISE  = 2'd0,
        OP_WR_FALL  = 2'd1,
        OP_RESTART  = 2'd2,
        OP_GENERATE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_SEED_LOW  = 2'd0,
        CFG_SEED_HIGH = 2'd1,
        CFG_REF_MEAN  = 2'd2,
        CFG_REF_RANGE = 2'd3
    } t_cfg_idx;

    // Commands to the index generators, already qualified by a transfer
    typedef struct packed {
        logic restart;
        logic generate_req;
    } t_lfsr_cmd;

endpackage

@@ hdl/lfsr_paired_delay_difference_top.sv @@
// A generate transfer reaches the output register through the table read and calibration stages.
// Throughput: one item per cycle; the table read and the five-stage calibration
// pipeline (two multiplier stages) all advance together and stall only on output backpressure.
// Write and restart items complete in the cycle of their transfer and give no result.
// Reset (i_rst_n, synchronous, active low) clears the LFSRs, control and config registers (range
// set to 16); the delay tables are not cleared and hold undefined data until written.
module lfsr_paired_delay_difference_top import pdd_pkg::*; #(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,   // address[10:0], value[25:11], zero pad
    input  logic [1:0]             i_s_axis_tuser,   // operation[1:0]
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,   // difference[15:0], calibrated[35:16], zero pad
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    t_op                      in_op;
    logic                     in_xfer;
    logic                     cfg_xfer;
    logic                     stall;
    logic                     adv;
    logic                     gen_xfer;
    t_lfsr_cmd                lfsr_cmd;
    logic [LFSR_W-1:0]        idx_low;
    logic [LFSR_W-1:0]        idx_high;
    logic [ADDR_F_W-1:0]      in_addr;
    logic [VALUE_W-1:0]       in_value;
    logic [VALUE_W-1:0]       rise_data;
    logic [VALUE_W-1:0]       fall_data;
    logic                     cal_valid;
    logic [DIFF_W-1:0]        cal_diff;
    logic [CAL_W-1:0]         cal_value;

    logic [LFSR_W-1:0]        r_seed_low;
    logic [LFSR_W-1:0]        r_seed_high;
    logic signed [MEAN_W-1:0] r_ref_mean;
    logic [RANGE_W-1:0]       r_ref_range;
    logic                     r_mem_valid;
    logic                     r_out_valid;
    logic [DIFF_W-1:0]        r_out_diff;
    logic [CAL_W-1:0]         r_out_cal;

    // Handshake and decode
    assign stall           = r_out_valid && !i_m_axis_tready;
    assign adv             = !stall;
    assign o_s_axis_tready = adv;
    assign o_cfg_ready     = 1'b1;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_xfer        = i_cfg_valid && o_cfg_ready;
    assign in_op           = t_op'(i_s_axis_tuser);
    assign in_addr         = i_s_axis_tdata[ADDR_LSB +: ADDR_F_W];
    assign in_value        = i_s_axis_tdata[VALUE_LSB +: VALUE_W];
    assign gen_xfer        = in_xfer && (in_op == OP_GENERATE);

    assign lfsr_cmd.restart      = in_xfer && (in_op == OP_RESTART);
    assign lfsr_cmd.generate_req = gen_xfer;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_low  <= '0;
            r_seed_high <= '0;
            r_ref_mean  <= '0;
            r_ref_range <= RANGE_W'(16);
        end else if (cfg_xfer) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SEED_LOW:  r_seed_low  <= i_cfg_data[LFSR_W-1:0];
                CFG_SEED_HIGH: r_seed_high <= i_cfg_data[LFSR_W-1:0];
                CFG_REF_MEAN:  r_ref_mean  <= $signed(i_cfg_data);
                CFG_REF_RANGE: r_ref_range <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pdd_lfsr u_lfsr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (lfsr_cmd),
        .i_seed_low  (r_seed_low),
        .i_seed_high (r_seed_high),
        .o_idx_low   (idx_low),
        .o_idx_high  (idx_high)
    );

    pdd_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_W)
    ) u_rise_table (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && (in_op == OP_WR_RISE)),
        .i_wr_addr (in_addr[ADDR_W-1:0]),
        .i_wr_data (in_value),
        .i_rd_en   (gen_xfer),
        .i_rd_addr (idx_high[ADDR_W-1:0]),
        .o_rd_data (rise_data)
    );

    pdd_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_W)
    ) u_fall_table (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && (in_op == OP_WR_FALL)),
        .i_wr_addr (in_addr[ADDR_W-1:0]),
        .i_wr_data (in_value),
        .i_rd_en   (gen_xfer),
        .i_rd_addr (idx_low[ADDR_W-1:0]),
        .o_rd_data (fall_data)
    );

    // Track the read data that belongs to a generate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= 1'b0;
        end else if (adv) begin
            r_mem_valid <= gen_xfer;
        end
    end

    pdd_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_mem_valid),
        .i_rise  (rise_data),
        .i_fall  (fall_data),
        .i_range (r_ref_range),
        .i_mean  (r_ref_mean),
        .o_valid (cal_valid),
        .o_diff  (cal_diff),
        .o_cal   (cal_value)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= cal_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_diff <= cal_diff;
            r_out_cal  <= cal_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - CAL_W - DIFF_W)'(0), r_out_cal, r_out_diff};

    // A generate transfer always leaves valid read data behind it
    a_gen_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_xfer |=> r_mem_valid)
        else $error("generate transfer did not mark table read data valid");

    // Any other transfer leaves no read data in flight
    a_nongen_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !gen_xfer) |=> !r_mem_valid)
        else $error("table read data marked valid without a generate");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // No new input is taken while a result waits to be taken
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !in_xfer)
        else $error("input transfer during output stall");

endmodule

@@ hdl/pdd_table.sv @@
module pdd_table #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/pdd_lfsr.sv @@
module pdd_lfsr import pdd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lfsr_cmd         i_cmd,
    input  logic [LFSR_W-1:0] i_seed_low,
    input  logic [LFSR_W-1:0] i_seed_high,
    output logic [LFSR_W-1:0] o_idx_low,
    output logic [LFSR_W-1:0] o_idx_high
);

    logic [LFSR_W-1:0] r_low;
    logic [LFSR_W-1:0] r_high;
    logic              r_first;
    logic [LFSR_W-1:0] n_low;
    logic [LFSR_W-1:0] n_high;
    logic              n_first;

    // Shift left, feed back bit10 ^ bit8 ^ NOR(bits 9..0)
    function automatic logic [LFSR_W-1:0] lfsr_adv(input logic [LFSR_W-1:0] s);
        logic fb;
        fb = s[10] ^ s[8] ^ (s[9:0] == 10'd0);
        return {s[LFSR_W-2:0], fb};
    endfunction

    // Reload on restart, advance on generate unless the seeds are still unused
    always_comb begin
        n_low   = r_low;
        n_high  = r_high;
        n_first = r_first;
        if (i_cmd.restart) begin
            n_low   = i_seed_low;
            n_high  = i_seed_high;
            n_first = 1'b1;
        end else if (i_cmd.generate_req) begin
            n_first = 1'b0;
            if (!r_first) begin
                n_low  = lfsr_adv(r_low);
                n_high = lfsr_adv(r_high);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_high  <= '0;
            r_first <= 1'b1;
        end else begin
            r_low   <= n_low;
            r_high  <= n_high;
            r_first <= n_first;
        end
    end

    // Table indexes for the generate being transferred this cycle
    assign o_idx_low  = n_low;
    assign o_idx_high = n_high;

endmodule

@@ hdl/pdd_cal.sv @@
module pdd_cal import pdd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  logic [VALUE_W-1:0]       i_rise,
    input  logic [VALUE_W-1:0]       i_fall,
    input  logic [RANGE_W-1:0]       i_range,
    input  logic signed [MEAN_W-1:0] i_mean,
    output logic                     o_valid,
    output logic [DIFF_W-1:0]        o_diff,
    output logic [CAL_W-1:0]         o_cal
);

    logic r_vb, r_vc, r_vd, r_ve, r_vf;

    logic signed [DIFF_W-1:0] r_diff_b, r_diff_c, r_diff_d, r_diff_e, r_diff_f;
    logic                     r_neg_c, r_neg_d, r_neg_e, r_neg_f;
    logic [19:0]              r_mag_c;
    logic [35:0]              r_m1_d;
    logic [36:0]              r_pl_e;
    logic [36:0]              r_ph_e;
    logic [22:0]              r_qm_f;

    logic signed [DIFF_W-1:0] n_diff_b;
    logic signed [20:0]       n_num_c;
    logic                     n_neg_c;
    logic [19:0]              n_mag_c;
    logic [35:0]              n_m1_d;
    logic [36:0]              n_pl_e;
    logic [36:0]              n_ph_e;
    logic [54:0]              n_sum_f;
    logic signed [23:0]       q_signed;
    logic signed [24:0]       cal_sum;
    logic signed [24:0]       cal_sat;

    // Difference of the two table entries
    assign n_diff_b = $signed({1'b0, i_rise}) - $signed({1'b0, i_fall});

    // Offset in Q8, then split into sign and magnitude
    assign n_num_c = $signed({r_diff_b[DIFF_W-1], r_diff_b, 4'b0000}) + CAL_OFFSET_Q8;
    assign n_neg_c = n_num_c[20];
    assign n_mag_c = n_neg_c ? 20'(-n_num_c) : n_num_c[19:0];

    // Scale by range
    assign n_m1_d = {16'b0, r_mag_c} * {20'b0, i_range};

    // Multiply by the reciprocal in two halves
    assign n_pl_e = {19'b0, r_m1_d[17:0]} * {18'b0, CAL_RECIP_Q24};
    assign n_ph_e = {19'b0, r_m1_d[35:18]} * {18'b0, CAL_RECIP_Q24};

    // Recombine, round half away from zero on the magnitude
    assign n_sum_f = {r_ph_e, 18'b0} + {18'b0, r_pl_e} + CAL_ROUND;

    // Restore the sign, add the mean, saturate
    always_comb begin
        q_signed = r_neg_f ? -$signed({1'b0, r_qm_f}) : $signed({1'b0, r_qm_f});
        cal_sum  = $signed({q_signed[23], q_signed})
                 + $signed({{9{i_mean[MEAN_W-1]}}, i_mean});
        if (cal_sum > CAL_MAX) begin
            cal_sat = CAL_MAX;
        end else if (cal_sum < CAL_MIN) begin
            cal_sat = CAL_MIN;
        end else begin
            cal_sat = cal_sum;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else if (i_adv) begin
            r_vb <= i_valid;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
        end
    end

    // Stage payloads, held while the output side stalls
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_diff_b <= n_diff_b;
            r_diff_c <= r_diff_b;
            r_neg_c  <= n_neg_c;
            r_mag_c  <= n_mag_c;
            r_diff_d <= r_diff_c;
            r_neg_d  <= r_neg_c;
            r_m1_d   <= n_m1_d;
            r_diff_e <= r_diff_d;
            r_neg_e  <= r_neg_d;
            r_pl_e   <= n_pl_e;
            r_ph_e   <= n_ph_e;
            r_diff_f <= r_diff_e;
            r_neg_f  <= r_neg_e;
            r_qm_f   <= n_sum_f[54:32];
        end
    end

    assign o_valid = r_vf;
    assign o_diff  = r_diff_f;
    assign o_cal   = cal_sat[CAL_W-1:0];

endmodule
